@@ rtl/core/mbconv_pkg.sv @@
// shared types, constants and functions for the modbus ascii to rtu converter
package mbconv_pkg;

    localparam logic [7:0]  FRAME_MARK = 8'h3A;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam int          MAX_RES    = 3;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_COLON = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] rtu_byte;
        logic       frame_end;
        status_t    status;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t [MAX_RES-1:0] res;
    } res_group_t;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        case (c) inside
            [8'h30:8'h39]: v = 4'(c - 8'h30);
            [8'h41:8'h46]: v = 4'(c - 8'h37);
            [8'h61:8'h66]: v = 4'(c - 8'h57);
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mbconv_frame.sv @@
// frame state, hex pairing, byte hold-back and crc for one beat per cycle while step is high
module mbconv_frame import mbconv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] ascii_char,
    input  logic       last_char,
    output res_group_t group
);

    logic        at_start_reg, at_start_next;
    logic        low_next_reg, low_next_next;
    logic [3:0]  high_reg, high_next;
    logic [7:0]  pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [15:0] crc_reg, crc_next;
    logic        rejected_reg, rejected_next;

    logic [3:0]  dv;
    logic [7:0]  new_byte;
    logic        completed;
    logic [15:0] crc_upd;
    logic        clear;

    assign dv       = digit_value(ascii_char);
    assign new_byte = {high_reg, dv};
    assign crc_upd  = crc_byte(crc_reg, pend_reg);

    always_comb
    begin
        at_start_next   = at_start_reg;
        low_next_next   = low_next_reg;
        high_next       = high_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        crc_next        = crc_reg;
        rejected_next   = rejected_reg;
        completed       = 1'b0;
        clear           = 1'b0;
        group.count     = 2'd0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            group.res[k] = '{rtu_byte: 8'h00, frame_end: 1'b0, status: STATUS_OK};
        end

        if (at_start_reg)
        begin
            at_start_next = 1'b0;
            if (ascii_char != FRAME_MARK)
                rejected_next = 1'b1;
            if (last_char)
            begin
                group.count = 2'd1;
                group.res[0].frame_end = 1'b1;
                group.res[0].status = (ascii_char != FRAME_MARK) ? STATUS_NO_COLON
                                                                 : STATUS_SHORT;
                clear = 1'b1;
            end
        end
        else if (rejected_reg)
        begin
            if (last_char)
            begin
                group.count = 2'd1;
                group.res[0].frame_end = 1'b1;
                group.res[0].status = STATUS_NO_COLON;
                clear = 1'b1;
            end
        end
        else
        begin
            if (!low_next_reg)
            begin
                high_next     = dv;
                low_next_next = 1'b1;
            end
            else
            begin
                low_next_next = 1'b0;
                completed     = 1'b1;
            end

            if (!last_char)
            begin
                if (completed)
                begin
                    if (pend_valid_reg)
                    begin
                        crc_next = crc_upd;
                        group.count = 2'd1;
                        group.res[0].rtu_byte = pend_reg;
                    end
                    pend_next       = new_byte;
                    pend_valid_next = 1'b1;
                end
            end
            else
            begin
                clear = 1'b1;
                if (pend_valid_reg)
                begin
                    group.count = 2'd3;
                    group.res[0].rtu_byte = pend_reg;
                    group.res[1].rtu_byte = crc_upd[7:0];
                    group.res[2].rtu_byte = crc_upd[15:8];
                    group.res[2].frame_end = 1'b1;
                end
                else
                begin
                    group.count = 2'd2;
                    group.res[0].rtu_byte = crc_reg[7:0];
                    group.res[1].rtu_byte = crc_reg[15:8];
                    group.res[1].frame_end = 1'b1;
                end
            end
        end

        if (clear)
        begin
            at_start_next   = 1'b1;
            low_next_next   = 1'b0;
            high_next       = 4'd0;
            pend_next       = 8'h00;
            pend_valid_next = 1'b0;
            crc_next        = CRC_INIT;
            rejected_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            low_next_reg   <= 1'b0;
            high_reg       <= 4'd0;
            pend_reg       <= 8'h00;
            pend_valid_reg <= 1'b0;
            crc_reg        <= CRC_INIT;
            rejected_reg   <= 1'b0;
        end
        else if (step)
        begin
            at_start_reg   <= at_start_next;
            low_next_reg   <= low_next_next;
            high_reg       <= high_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            crc_reg        <= crc_next;
            rejected_reg   <= rejected_next;
        end
    end

endmodule

@@ rtl/core/modbus_ascii_to_rtu_converter.sv @@
// top level: modbus ascii to rtu converter with a short result queue
// Takes one ASCII character per beat, with last_char marking the end of the
// frame, and gives the RTU bytes of the frame followed by the CRC-16 low and
// high bytes, or a single status beat for a frame with no colon or only the
// colon. Each character is decoded in the cycle it is taken. Its results enter
// a four-entry queue at that edge: at most one result, or up to three at a
// frame end. The first is offered once the results ahead of it have left, and
// the rest follow one per cycle while out_ready is high. The input stalls while
// more than one result would be left waiting after the current output beat.
// With out_ready held high a character is taken every cycle, except while the CRC bytes of a frame end drain.
module modbus_ascii_to_rtu_converter import mbconv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ascii_char,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] rtu_byte,
    output logic       frame_end,
    output logic [1:0] status
);

    res_t [QUEUE_DEPTH-1:0] q_reg, q_next;
    logic [2:0]             count_reg, count_next;
    logic [2:0]             base;
    logic                   pop;
    logic                   push;
    res_group_t             group;

    assign pop       = (count_reg != 3'd0) && out_ready;
    assign base      = count_reg - {2'd0, pop};
    assign in_ready  = (base <= 3'd1);
    assign push      = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign rtu_byte  = q_reg[0].rtu_byte;
    assign frame_end = q_reg[0].frame_end;
    assign status    = q_reg[0].status;

    mbconv_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (push),
        .ascii_char (ascii_char),
        .last_char  (last_char),
        .group      (group)
    );

    always_comb
    begin
        q_next = q_reg;
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
        end
        if (push)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                for (int k = 0; k < MAX_RES; k++)
                begin
                    if ((3'(k) < {1'b0, group.count}) && (base + 3'(k) == 3'(i)))
                        q_next[i] = group.res[k];
                end
            end
            count_next = base + {1'b0, group.count};
        end
        else
        begin
            count_next = base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

@@ sim/modbus_ascii_to_rtu_converter_tb.sv @@
// testbench for the modbus ascii to rtu converter: queued driver, monitor and frame predictor
`timescale 1ns / 100ps

module modbus_ascii_to_rtu_converter_tb;
    import mbconv_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain_first;
    } char_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ascii_char = 8'h00;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] rtu_byte;
    logic       frame_end;
    logic [1:0] status;

    char_beat_t char_q[$];
    res_t       rtu_q[$];

    int  err_cnt = 0;
    int  beats_in = 0;
    int  n_items = 0;
    bit  next_drain = 1'b0;
    int  idle_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // predictor state
    bit          sof_wait;
    bit          lo_next;
    logic [3:0]  hi_nib;
    logic [7:0]  held_byte;
    bit          held_ok;
    logic [15:0] crc_run;
    bit          bad_frame;

    modbus_ascii_to_rtu_converter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ascii_char (ascii_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rtu_byte   (rtu_byte),
        .frame_end  (frame_end),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c[3:0];
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void clear_frame();
        sof_wait  = 1'b1;
        lo_next   = 1'b0;
        hi_nib    = 4'd0;
        held_byte = 8'h00;
        held_ok   = 1'b0;
        crc_run   = CRC_INIT;
        bad_frame = 1'b0;
    endfunction

    function automatic void add_rtu(input logic [7:0] b, input logic fe, input status_t st);
        res_t r;
        r.rtu_byte  = b;
        r.frame_end = fe;
        r.status    = st;
        rtu_q.push_back(r);
    endfunction

    function automatic void convert_char(input logic [7:0] c, input logic last);
        logic [7:0] b;
        bit         done;
        b    = 8'h00;
        done = 1'b0;
        if (sof_wait)
        begin
            sof_wait = 1'b0;
            if (c != FRAME_MARK)
                bad_frame = 1'b1;
            if (last)
            begin
                add_rtu(8'h00, 1'b1, bad_frame ? STATUS_NO_COLON : STATUS_SHORT);
                clear_frame();
            end
        end
        else if (bad_frame)
        begin
            if (last)
            begin
                add_rtu(8'h00, 1'b1, STATUS_NO_COLON);
                clear_frame();
            end
        end
        else
        begin
            if (!lo_next)
            begin
                hi_nib  = nibble_of(c);
                lo_next = 1'b1;
            end
            else
            begin
                b       = {hi_nib, nibble_of(c)};
                lo_next = 1'b0;
                done    = 1'b1;
            end
            if (!last)
            begin
                if (done)
                begin
                    if (held_ok)
                    begin
                        crc_run = crc16_step(crc_run, held_byte);
                        add_rtu(held_byte, 1'b0, STATUS_OK);
                    end
                    held_byte = b;
                    held_ok   = 1'b1;
                end
            end
            else
            begin
                if (held_ok)
                begin
                    crc_run = crc16_step(crc_run, held_byte);
                    add_rtu(held_byte, 1'b0, STATUS_OK);
                end
                add_rtu(crc_run[7:0], 1'b0, STATUS_OK);
                add_rtu(crc_run[15:8], 1'b1, STATUS_OK);
                clear_frame();
            end
        end
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic last);
        char_beat_t t;
        t.ch          = c;
        t.last        = last;
        t.drain_first = next_drain;
        next_drain    = 1'b0;
        char_q.push_back(t);
        n_items++;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        if ($urandom_range(0, 1))
            return 8'("A" + v - 10);
        return 8'("a" + v - 10);
    endfunction

    function automatic void add_random_frame();
        logic [7:0] fr[$];
        int         kind;
        int         len;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            len = $urandom_range(1, 7);
            repeat (len)
                fr.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 1)
        begin
            fr.push_back(FRAME_MARK);
            len = $urandom_range(0, 8);
            repeat (len)
                fr.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            fr.push_back(FRAME_MARK);
            len = $urandom_range(1, 8);
            repeat (2 * len)
                fr.push_back(hex_char());
            if ($urandom_range(0, 7) == 0)
                void'(fr.pop_back());
            if (fr.size() > 1 && $urandom_range(0, 9) == 0)
                fr[$urandom_range(1, fr.size() - 1)] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < fr.size(); i++)
            push_char(fr[i], i == fr.size() - 1);
    endfunction

    // driver
    always @(posedge clk)
    begin : drive_proc
        char_beat_t cur;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                convert_char(ascii_char, last_char);
                beats_in++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the beat
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (char_q.size() != 0 && !(char_q[0].drain_first && rtu_q.size() != 0))
            begin
                cur = char_q.pop_front();
                ascii_char <= cur.ch;
                last_char  <= cur.last;
                in_valid   <= 1'b1;
                if (char_q.size() >= 80 && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 15);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin : recv_proc
        bit rdy;
        if (rst_n)
        begin
            if (!hold_done && beats_in >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (char_q.size() < 80)
            begin
                rdy = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // monitor
    always @(posedge clk)
    begin : mon_proc
        res_t r;
        if (rst_n && out_valid && out_ready)
        begin
            if (rtu_q.size() == 0)
            begin
                $error("unexpected beat: rtu_byte %0h frame_end %0b status %0d",
                       rtu_byte, frame_end, status);
                err_cnt++;
            end
            else
            begin
                r = rtu_q.pop_front();
                if (rtu_byte !== r.rtu_byte)
                begin
                    $error("rtu_byte expected %0h actual %0h", r.rtu_byte, rtu_byte);
                    err_cnt++;
                end
                if (frame_end !== r.frame_end)
                begin
                    $error("frame_end expected %0b actual %0b", r.frame_end, frame_end);
                    err_cnt++;
                end
                if (status !== r.status)
                begin
                    $error("status expected %0d actual %0d", r.status, status);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int drain_mark;
        clear_frame();

        // colon only, no colon, rejected longer frame
        push_char(":", 1'b1);
        push_char("A", 1'b1);
        push_char("X", 1'b0);
        push_char("1", 1'b0);
        push_char("2", 1'b1);
        // two characters: crc of nothing
        push_char(":", 1'b0);
        push_char("F", 1'b1);
        // mixed case, extremes 00 and ff
        push_char(":", 1'b0);
        push_char("0", 1'b0);
        push_char("0", 1'b0);
        push_char("F", 1'b0);
        push_char("f", 1'b0);
        push_char("1", 1'b0);
        push_char("2", 1'b1);
        // non-hex characters, a colon inside the frame
        push_char(":", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char("g", 1'b0);
        push_char(":", 1'b0);
        push_char("9", 1'b1);
        // odd digit count
        push_char(":", 1'b0);
        push_char("a", 1'b0);
        push_char("B", 1'b0);
        push_char("3", 1'b1);

        next_drain = 1'b1;
        drain_mark = n_items + 150;
        while (n_items < 475)
        begin
            if (n_items >= drain_mark)
            begin
                next_drain = 1'b1;
                drain_mark += 150;
            end
            add_random_frame();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_in != n_items)
            @(posedge clk);
        while (rtu_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
